>>> hdl/rtpbb_pkg.sv
package rtpbb_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned RAD_W   = 5;
  localparam int unsigned DVS_W   = 6;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned BRAD_W  = 6;

  localparam int unsigned DEF_MAX_WIDTH   = 256;
  localparam int unsigned DEF_MAX_HEIGHT  = 256;
  localparam int unsigned DEF_PASS_ROUNDS = 3;

  typedef logic [LANES-1:0][PIX_W-1:0] pixel_t;
  typedef logic [LANES-1:0][SUM_W-1:0] lane_sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_BLUR_RADIUS  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_e;

endpackage

>>> hdl/rtpbb_ram.sv
module rtpbb_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/rtpbb_div.sv
module rtpbb_div
  import rtpbb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lane_sum_t        dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output pixel_t           quot_o,
  output logic             done_o
);

  // restoring division, one quotient bit per cycle; quotient known to fit 8 bits
  lane_sum_t          rem_q;
  pixel_t             quot_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [STEP_W-1:0]  step_q;
  logic               busy_q;
  logic               done_q;
  logic [SUM_W-1:0]   shifted;

  assign shifted = SUM_W'(dvs_q) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(PIX_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      for (int c = 0; c < LANES; c++) begin
        if (rem_q[c] >= shifted) begin
          rem_q[c]  <= rem_q[c] - shifted;
          quot_q[c] <= {quot_q[c][PIX_W-2:0], 1'b1};
        end else begin
          quot_q[c] <= {quot_q[c][PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

>>> hdl/rtpbb_engine.sv
module rtpbb_engine
  import rtpbb_pkg::*;
#(
  parameter int unsigned LW          = 9,
  parameter int unsigned AW          = 16,
  parameter int unsigned IW          = 11,
  parameter int unsigned RW          = 2,
  parameter int unsigned PASS_ROUNDS = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LW-1:0]    width_i,
  input  logic [LW-1:0]    height_i,
  input  logic [RAD_W-1:0] radius_i,
  output logic             done_o,
  output logic [AW-1:0]    addr_o,
  input  pixel_t           frame_rdata_i,
  input  pixel_t           scratch_rdata_i,
  output logic             frame_we_o,
  output logic             scratch_we_o,
  output pixel_t           wdata_o
);

  typedef enum logic [9:0] {
    E_IDLE    = 10'b0000000001,
    E_LINE    = 10'b0000000010,
    E_PRE_RD  = 10'b0000000100,
    E_PRE_ACC = 10'b0000001000,
    E_DIV_GO  = 10'b0000010000,
    E_DIV     = 10'b0000100000,
    E_ADD_RD  = 10'b0001000000,
    E_ADD_ACC = 10'b0010000000,
    E_SUB_RD  = 10'b0100000000,
    E_SUB_ACC = 10'b1000000000
  } eng_state_e;

  eng_state_e             st_q, st_d;
  logic [LW-1:0]          w_q, h_q, l_q, l_d, x_q, x_d;
  logic [RAD_W-1:0]       r_q;
  logic                   dir_q, dir_d;
  logic [RW-1:0]          round_q, round_d;
  logic signed [IW-1:0]   j_q, j_d;
  lane_sum_t              sum_q, sum_d, dividend;
  logic                   done_q, done_d;

  logic [LW-1:0]          len, lines, k, mul_a, offs;
  logic signed [IW-1:0]   idx, len_s, x_s, r_s;
  logic [2*LW-1:0]        addr_full;
  pixel_t                 src_px, quot;
  logic                   div_done;

  assign len   = dir_q ? h_q : w_q;
  assign lines = dir_q ? w_q : h_q;
  assign len_s = signed'(IW'(len));
  assign x_s   = signed'(IW'(x_q));
  assign r_s   = signed'(IW'(r_q));

  always_comb begin
    case (st_q)
      E_PRE_RD: idx = j_q;
      E_ADD_RD: idx = x_s + r_s + IW'(1);
      E_SUB_RD: idx = x_s - r_s;
      default:  idx = x_s;
    endcase
    if (idx < 0) begin
      k = '0;
    end else if (idx >= len_s) begin
      k = len - 1'b1;
    end else begin
      k = idx[LW-1:0];
    end
    mul_a = dir_q ? k : l_q;
    offs  = dir_q ? l_q : k;
  end

  assign addr_full = (2*LW)'(mul_a) * (2*LW)'(w_q) + (2*LW)'(offs);
  assign addr_o    = AW'(addr_full);
  assign src_px    = dir_q ? scratch_rdata_i : frame_rdata_i;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      dividend[c] = sum_q[c] + SUM_W'(r_q);
    end
  end

  rtpbb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_q == E_DIV_GO),
    .dividend_i (dividend),
    .divisor_i  ({r_q, 1'b1}),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign wdata_o      = quot;
  assign frame_we_o   = (st_q == E_DIV) && div_done && dir_q;
  assign scratch_we_o = (st_q == E_DIV) && div_done && !dir_q;
  assign done_o       = done_q;

  always_comb begin
    st_d    = st_q;
    l_d     = l_q;
    x_d     = x_q;
    j_d     = j_q;
    dir_d   = dir_q;
    round_d = round_q;
    sum_d   = sum_q;
    done_d  = 1'b0;
    case (st_q)
      E_IDLE: begin
        if (start_i) begin
          l_d     = '0;
          dir_d   = 1'b0;
          round_d = '0;
          st_d    = E_LINE;
        end
      end
      E_LINE: begin
        sum_d = '0;
        j_d   = -r_s;
        st_d  = E_PRE_RD;
      end
      E_PRE_RD: st_d = E_PRE_ACC;
      E_PRE_ACC: begin
        for (int c = 0; c < LANES; c++) begin
          sum_d[c] = sum_q[c] + SUM_W'(src_px[c]);
        end
        if (j_q == r_s) begin
          x_d  = '0;
          st_d = E_DIV_GO;
        end else begin
          j_d  = j_q + IW'(1);
          st_d = E_PRE_RD;
        end
      end
      E_DIV_GO: st_d = E_DIV;
      E_DIV: begin
        if (div_done) begin
          if (x_q != len - 1'b1) begin
            st_d = E_ADD_RD;
          end else if (l_q != lines - 1'b1) begin
            l_d  = l_q + 1'b1;
            st_d = E_LINE;
          end else if (!dir_q) begin
            dir_d = 1'b1;
            l_d   = '0;
            st_d  = E_LINE;
          end else if (round_q == RW'(PASS_ROUNDS - 1)) begin
            done_d = 1'b1;
            st_d   = E_IDLE;
          end else begin
            round_d = round_q + 1'b1;
            dir_d   = 1'b0;
            l_d     = '0;
            st_d    = E_LINE;
          end
        end
      end
      E_ADD_RD: st_d = E_ADD_ACC;
      E_ADD_ACC: begin
        for (int c = 0; c < LANES; c++) begin
          sum_d[c] = sum_q[c] + SUM_W'(src_px[c]);
        end
        st_d = E_SUB_RD;
      end
      E_SUB_RD: st_d = E_SUB_ACC;
      E_SUB_ACC: begin
        for (int c = 0; c < LANES; c++) begin
          sum_d[c] = sum_q[c] - SUM_W'(src_px[c]);
        end
        x_d  = x_q + 1'b1;
        st_d = E_DIV_GO;
      end
      default: st_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= E_IDLE;
      done_q  <= 1'b0;
      dir_q   <= 1'b0;
      round_q <= '0;
      l_q     <= '0;
      x_q     <= '0;
    end else begin
      st_q    <= st_d;
      done_q  <= done_d;
      dir_q   <= dir_d;
      round_q <= round_d;
      l_q     <= l_d;
      x_q     <= x_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    sum_q <= sum_d;
    if (start_i && st_q == E_IDLE) begin
      w_q <= width_i;
      h_q <= height_i;
      r_q <= radius_i;
    end
  end

endmodule

>>> hdl/rgba_three_pass_box_blur.sv
// Frame-at-a-time RGBA blur. Load items write pixels in raster order; the last
// pixel of the frame starts the blur, during which no item is taken. The blur
// runs PASS_ROUNDS rounds of a horizontal and a vertical box pass, one pixel at
// a time through a single running-sum datapath and a shared four-lane restoring
// divider; the run time is set mostly by the divider and the two store reads per
// step. Fetch items read the stored frame through one registered store read.
// Blur radius 0 makes the frame ready straight after the last load.
module rgba_three_pass_box_blur
  import rtpbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned PASS_ROUNDS = DEF_PASS_ROUNDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [PIX_W-1:0]     red_in_i,
  input  logic [PIX_W-1:0]     green_in_i,
  input  logic [PIX_W-1:0]     blue_in_i,
  input  logic [PIX_W-1:0]     alpha_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     red_out_o,
  output logic [PIX_W-1:0]     green_out_o,
  output logic [PIX_W-1:0]     blue_out_o,
  output logic [PIX_W-1:0]     alpha_out_o,
  output logic                 last_pixel_o,
  output logic                 ready_res_o
);

  localparam int unsigned MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned LW    = $clog2(MAXD + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned IW    = ((LW > RAD_W + 1) ? LW : RAD_W + 1) + 2;
  localparam int unsigned RW    = $clog2(PASS_ROUNDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_BLUR  = 3'b100
  } top_state_e;

  top_state_e          st_q, st_d;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [BRAD_W-1:0]   radius_q;
  logic [AW-1:0]       load_pos_q, load_pos_d, fetch_pos_q, fetch_pos_d;
  logic                ready_q, ready_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  pixel_t              out_px_q, out_px_d;
  logic                out_last_q, out_last_d, out_res_q, out_res_d;

  logic [LW-1:0]       eff_w, eff_h;
  logic [RAD_W-1:0]    eff_r;
  logic [NW-1:0]       n_pix;
  logic [AW-1:0]       load_sel, fetch_sel;
  logic                in_acc, eng_start, eng_done;

  logic [AW-1:0]       eng_addr, frame_raddr, frame_waddr;
  logic                eng_frame_we, eng_scratch_we, frame_we;
  pixel_t              eng_wdata, frame_wdata, frame_rdata, scratch_rdata, in_px;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      radius_q <= BRAD_W'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_BLUR_RADIUS:  radius_q <= cfg_data_i[BRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = LW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = LW'(MAX_WIDTH);
    end else begin
      eff_w = LW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = LW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = LW'(MAX_HEIGHT);
    end else begin
      eff_h = LW'(height_q);
    end
    eff_r = (radius_q[BRAD_W-1:1] == '0) ? RAD_W'(1) : radius_q[BRAD_W-1:1];
  end

  assign n_pix     = NW'(eff_w) * NW'(eff_h);
  assign load_sel  = ready_q ? '0 : load_pos_q;
  assign fetch_sel = (NW'(fetch_pos_q) >= n_pix) ? '0 : fetch_pos_q;

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_px      = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  always_comb begin
    st_d        = st_q;
    load_pos_d  = load_pos_q;
    fetch_pos_d = fetch_pos_q;
    ready_d     = ready_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_px_d    = out_px_q;
    out_last_d  = out_last_q;
    out_res_d   = out_res_q;
    eng_start   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && kind_i == KIND_LOAD) begin
          ready_d = 1'b0;
          if (NW'(load_sel) + NW'(1) >= n_pix) begin
            load_pos_d  = '0;
            fetch_pos_d = '0;
            if (radius_q == '0) begin
              ready_d = 1'b1;
            end else begin
              eng_start = 1'b1;
              st_d      = ST_BLUR;
            end
          end else begin
            load_pos_d = load_sel + 1'b1;
          end
        end else if (in_acc) begin
          if (ready_q) begin
            last_d      = (NW'(fetch_sel) == n_pix - 1'b1);
            fetch_pos_d = last_d ? '0 : fetch_sel + 1'b1;
            st_d        = ST_FETCH;
          end else begin
            out_valid_d = 1'b1;
            out_px_d    = '0;
            out_last_d  = 1'b0;
            out_res_d   = 1'b0;
          end
        end
      end
      ST_FETCH: begin
        out_valid_d = 1'b1;
        out_px_d    = frame_rdata;
        out_last_d  = last_q;
        out_res_d   = 1'b1;
        st_d        = ST_IDLE;
      end
      ST_BLUR: begin
        if (eng_done) begin
          ready_d = 1'b1;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      load_pos_q  <= '0;
      fetch_pos_q <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      load_pos_q  <= load_pos_d;
      fetch_pos_q <= fetch_pos_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    out_px_q   <= out_px_d;
    out_last_q <= out_last_d;
    out_res_q  <= out_res_d;
  end

  // store ports: the blur engine owns both stores while it runs
  assign frame_raddr = (st_q == ST_BLUR) ? eng_addr : fetch_sel;
  assign frame_waddr = (st_q == ST_BLUR) ? eng_addr : load_sel;
  assign frame_wdata = (st_q == ST_BLUR) ? eng_wdata : in_px;
  assign frame_we    = (st_q == ST_BLUR) ? eng_frame_we
                                         : (in_acc && kind_i == KIND_LOAD);

  rtpbb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (LANES * PIX_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  rtpbb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (LANES * PIX_W)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (eng_scratch_we),
    .waddr_i (eng_addr),
    .wdata_i (eng_wdata),
    .raddr_i (eng_addr),
    .rdata_o (scratch_rdata)
  );

  rtpbb_engine #(
    .LW          (LW),
    .AW          (AW),
    .IW          (IW),
    .RW          (RW),
    .PASS_ROUNDS (PASS_ROUNDS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (eng_start),
    .width_i         (eff_w),
    .height_i        (eff_h),
    .radius_i        (eff_r),
    .done_o          (eng_done),
    .addr_o          (eng_addr),
    .frame_rdata_i   (frame_rdata),
    .scratch_rdata_i (scratch_rdata),
    .frame_we_o      (eng_frame_we),
    .scratch_we_o    (eng_scratch_we),
    .wdata_o         (eng_wdata)
  );

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_px_q[0];
  assign green_out_o  = out_px_q[1];
  assign blue_out_o   = out_px_q[2];
  assign alpha_out_o  = out_px_q[3];
  assign last_pixel_o = out_last_q;
  assign ready_res_o  = out_res_q;

endmodule
